FILE: hw/rtl/bpra_pkg.sv
// Shared constants, codes and controller/datapath types of the page-run allocator.
package bpra_pkg;

  localparam int NUM_PAGES = 65536;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int PE_W      = PAGE_W + 1;
  localparam int IDX_W     = 16;
  localparam int CNT_W     = 17;
  localparam int OP_W      = 3;
  localparam int WORD_W    = 64;
  localparam int WB        = $clog2(WORD_W);
  localparam int NWORDS    = NUM_PAGES / WORD_W;
  localparam int WA_W      = $clog2(NWORDS);
  localparam int POP_W     = WB + 1;
  localparam int SUM_W     = (PE_W > CNT_W + 1) ? PE_W + 1 : CNT_W + 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE   = 3'd1;
  localparam logic [OP_W-1:0] OP_LOCK      = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd3;
  localparam logic [OP_W-1:0] OP_MARK_USED = 3'd4;

  typedef enum logic [2:0] {
    WM_CHECK   = 3'd0,
    WM_SCAN    = 3'd1,
    WM_RELEASE = 3'd2,
    WM_LOCK    = 3'd3,
    WM_FREE    = 3'd4,
    WM_USED    = 3'd5
  } walk_mode_t;

  typedef enum logic [1:0] {
    RNG_HINT  = 2'd0,
    RNG_FULL  = 2'd1,
    RNG_ALLOC = 2'd2,
    RNG_ITEM  = 2'd3
  } range_sel_t;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       take_hint;
    logic       walk_start;
    logic       walk;
    walk_mode_t mode;
    range_sel_t rng;
    logic       set_fail;
    logic       finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic            clear_last;
    logic [OP_W-1:0] op;
    logic            cnt_zero;
    logic            hint_fits;
    logic            item_empty;
    logic            done;
    logic            chk_fail;
    logic            scan_hit;
    logic            out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/bpra_in_if.sv
// Input and result channel interfaces of the page-run allocator.
interface bpra_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [15:0] page_index;
  logic [16:0] page_count;
  modport source (output valid, operation, page_index, page_count, input ready);
  modport sink (input valid, operation, page_index, page_count, output ready);
endinterface

interface bpra_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] start_page;
  logic        status;
  logic [16:0] used_pages;
  modport source (output valid, start_page, status, used_pages, input ready);
  modport sink (input valid, start_page, status, used_pages, output ready);
endinterface

FILE: hw/rtl/bpra_ctl.sv
// Controller state machine of the page-run allocator.
module bpra_ctl import bpra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_DISPATCH = 8'b0000_0100,
    S_HINT     = 8'b0000_1000,
    S_SCAN     = 8'b0001_0000,
    S_LOCKGO   = 8'b0010_0000,
    S_APPLY    = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.mode       = WM_CHECK;
    cmd.rng        = RNG_HINT;
    in_ready       = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.op) inside
          OP_ALLOC: begin
            if (stat.cnt_zero) begin
              cmd.take_hint = 1'b1;
              state_nxt     = S_DONE;
            end else if (stat.hint_fits) begin
              cmd.walk_start = 1'b1;
              cmd.mode       = WM_CHECK;
              cmd.rng        = RNG_HINT;
              state_nxt      = S_HINT;
            end else begin
              cmd.walk_start = 1'b1;
              cmd.mode       = WM_SCAN;
              cmd.rng        = RNG_FULL;
              state_nxt      = S_SCAN;
            end
          end
          OP_RELEASE, OP_LOCK, OP_MARK_FREE, OP_MARK_USED: begin
            if (stat.item_empty) begin
              state_nxt = S_DONE;
            end else begin
              cmd.walk_start = 1'b1;
              cmd.rng        = RNG_ITEM;
              case (stat.op)
                OP_RELEASE:   cmd.mode = WM_RELEASE;
                OP_LOCK:      cmd.mode = WM_LOCK;
                OP_MARK_FREE: cmd.mode = WM_FREE;
                default:      cmd.mode = WM_USED;
              endcase
              state_nxt = S_APPLY;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_HINT: begin
        cmd.walk = 1'b1;
        if (stat.done) begin
          if (stat.chk_fail) begin
            cmd.walk_start = 1'b1;
            cmd.mode       = WM_SCAN;
            cmd.rng        = RNG_FULL;
            state_nxt      = S_SCAN;
          end else begin
            cmd.take_hint = 1'b1;
            state_nxt     = S_LOCKGO;
          end
        end
      end
      S_SCAN: begin
        cmd.walk = 1'b1;
        if (stat.done) begin
          if (stat.scan_hit) begin
            state_nxt = S_LOCKGO;
          end else begin
            cmd.set_fail = 1'b1;
            state_nxt    = S_DONE;
          end
        end
      end
      S_LOCKGO: begin
        cmd.walk_start = 1'b1;
        cmd.mode       = WM_LOCK;
        cmd.rng        = RNG_ALLOC;
        state_nxt      = S_APPLY;
      end
      S_APPLY: begin
        cmd.walk = 1'b1;
        if (stat.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

FILE: hw/rtl/bpra_dp.sv
// Datapath of the page-run allocator: occupancy memory, word walker, counters, result register.
module bpra_dp import bpra_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  ctl_cmd_t        cmd,
  output dp_stat_t        stat,
  input  logic [OP_W-1:0] in_operation,
  input  logic [IDX_W-1:0] in_page_index,
  input  logic [CNT_W-1:0] in_page_count,
  bpra_out_if.source      out_ch
);

  localparam logic [SUM_W-1:0] NP_S = SUM_W'(NUM_PAGES);

  logic [WORD_W-1:0] mem [NWORDS];
  logic [WORD_W-1:0] rdata_r;

  logic [OP_W-1:0]   op_r;
  logic [IDX_W-1:0]  first_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  hint_r;
  logic [IDX_W-1:0]  alloc_r;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic              fail_r;
  logic [WA_W-1:0]   clr_r;

  walk_mode_t        mode_r;
  logic              issue_r, pend_r;
  logic [WA_W-1:0]   rd_word_r, pend_word_r, word_lo_r, word_hi_r;
  logic [WB-1:0]     bit_lo_r, bit_hi_r;
  logic [SUM_W-1:0]  run_r, run_nxt;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_start_r;
  logic              out_status_r;
  logic [CNT_W-1:0]  out_used_r;

  logic [SUM_W-1:0]  sum_hint, sum_alloc, sum_item, item_hi, sel_lo, sel_hi, hi_m1;
  logic              proc, last, chk_fail, scan_hit, mem_we;
  logic [WORD_W-1:0] mask, sel_bits, mem_wd, hit;
  logic [POP_W-1:0]  flips;
  logic [WB-1:0]     hit_idx;
  logic [WA_W-1:0]   mem_wa;
  logic [SUM_W-1:0]  found;

  function automatic logic [POP_W-1:0] popcnt(input logic [WORD_W-1:0] v);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) c = c + POP_W'(v[i]);
    return c;
  endfunction

  assign sum_hint  = SUM_W'(hint_r) + SUM_W'(cnt_r);
  assign sum_alloc = SUM_W'(alloc_r) + SUM_W'(cnt_r);
  assign sum_item  = SUM_W'(first_r) + SUM_W'(cnt_r);
  assign item_hi   = (sum_item > NP_S) ? NP_S : sum_item;

  always_comb begin
    case (cmd.rng)
      RNG_HINT:  begin sel_lo = SUM_W'(hint_r);  sel_hi = sum_hint;  end
      RNG_FULL:  begin sel_lo = '0;              sel_hi = NP_S;      end
      RNG_ALLOC: begin sel_lo = SUM_W'(alloc_r); sel_hi = sum_alloc; end
      default:   begin sel_lo = SUM_W'(first_r); sel_hi = item_hi;   end
    endcase
  end
  assign hi_m1 = sel_hi - SUM_W'(1);

  // Bits of the current word that lie inside the walked page range.
  always_comb begin
    mask = '1;
    if (pend_word_r == word_lo_r) mask = mask & ({WORD_W{1'b1}} << bit_lo_r);
    if (pend_word_r == word_hi_r) mask = mask & ({WORD_W{1'b1}} >> ({WB{1'b1}} - bit_hi_r));
  end

  assign proc     = cmd.walk && pend_r;
  assign last     = (pend_word_r == word_hi_r);
  assign sel_bits = rdata_r & mask;
  assign chk_fail = (mode_r == WM_CHECK) && (sel_bits != '0);

  // A hit at bit i means the free run ending at page i reaches the requested length.
  always_comb begin
    logic [WORD_W-1:0] below, win;
    logic [WB-1:0]     sh;
    hit     = '0;
    hit_idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      below = {WORD_W{1'b1}} >> (WORD_W - 1 - i);
      sh    = WB'(CNT_W'(i + 1) - cnt_r);
      win   = below & ({WORD_W{1'b1}} << sh);
      if (cnt_r <= CNT_W'(i + 1)) begin
        hit[i] = ((rdata_r & win) == '0);
      end else begin
        hit[i] = ((rdata_r & below) == '0) &&
                 (run_r >= SUM_W'(cnt_r - CNT_W'(i + 1)));
      end
    end
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit[i]) hit_idx = WB'(i);
    end
  end

  always_comb begin
    logic [WB-1:0] top;
    top = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (rdata_r[i]) top = WB'(i);
    end
    if (rdata_r == '0) run_nxt = run_r + SUM_W'(WORD_W);
    else               run_nxt = SUM_W'({WB{1'b1}} - top);
  end

  assign scan_hit = (mode_r == WM_SCAN) && (hit != '0);
  assign found    = SUM_W'({pend_word_r, hit_idx}) + SUM_W'(1) - SUM_W'(cnt_r);

  always_comb begin
    flips  = '0;
    mem_wd = rdata_r;
    case (mode_r)
      WM_RELEASE: begin mem_wd = rdata_r & ~mask; flips = popcnt(sel_bits); end
      WM_LOCK:    begin mem_wd = rdata_r | mask;  flips = popcnt(~rdata_r & mask); end
      WM_FREE:    mem_wd = rdata_r & ~mask;
      WM_USED:    mem_wd = rdata_r | mask;
      default:    mem_wd = rdata_r;
    endcase
    if (cmd.clear) mem_wd = '1;
  end

  assign mem_we = cmd.clear || (proc && (mode_r != WM_CHECK) && (mode_r != WM_SCAN));
  assign mem_wa = cmd.clear ? clr_r : pend_word_r;

  always_comb begin
    used_nxt = used_r;
    if (proc && mode_r == WM_RELEASE) begin
      used_nxt = (used_r < CNT_W'(flips)) ? '0 : used_r - CNT_W'(flips);
    end else if (proc && mode_r == WM_LOCK) begin
      used_nxt = (COUNT_MAX - used_r < CNT_W'(flips)) ? COUNT_MAX : used_r + CNT_W'(flips);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[rd_word_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      hint_r      <= '0;
      used_r      <= '0;
      fail_r      <= 1'b0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) clr_r <= clr_r + WA_W'(1);
      used_r <= used_nxt;
      if (cmd.set_fail) fail_r <= 1'b1;
      if (cmd.walk_start) begin
        issue_r <= 1'b1;
        pend_r  <= 1'b0;
      end else if (cmd.walk) begin
        pend_r <= issue_r;
        if (issue_r && rd_word_r == word_hi_r) issue_r <= 1'b0;
      end else begin
        pend_r <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        fail_r      <= 1'b0;
        if (op_r == OP_RELEASE && cnt_r != '0) hint_r <= IDX_W'(sum_item - SUM_W'(1));
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      first_r <= in_page_index;
      cnt_r   <= in_page_count;
    end
    if (cmd.take_hint) alloc_r <= hint_r;
    else if (proc && scan_hit) alloc_r <= IDX_W'(found);
    if (cmd.walk_start) begin
      mode_r    <= cmd.mode;
      rd_word_r <= sel_lo[PAGE_W-1:WB];
      word_lo_r <= sel_lo[PAGE_W-1:WB];
      bit_lo_r  <= sel_lo[WB-1:0];
      word_hi_r <= hi_m1[PAGE_W-1:WB];
      bit_hi_r  <= hi_m1[WB-1:0];
      run_r     <= '0;
    end else if (cmd.walk) begin
      if (issue_r) begin
        pend_word_r <= rd_word_r;
        if (rd_word_r != word_hi_r) rd_word_r <= rd_word_r + WA_W'(1);
      end
      if (proc) run_r <= run_nxt;
    end
    if (cmd.finish) begin
      out_start_r  <= (op_r == OP_ALLOC && !fail_r) ? alloc_r : '0;
      out_status_r <= fail_r;
      out_used_r   <= used_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.start_page = out_start_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.used_pages = out_used_r;

  assign stat.clear_last = (clr_r == WA_W'(NWORDS - 1));
  assign stat.op         = op_r;
  assign stat.cnt_zero   = (cnt_r == '0);
  assign stat.hint_fits  = (sum_hint <= NP_S);
  assign stat.item_empty = (cnt_r == '0) || (SUM_W'(first_r) >= NP_S);
  assign stat.done       = proc && (last || chk_fail || scan_hit);
  assign stat.chk_fail   = proc && chk_fail;
  assign stat.scan_hit   = proc && scan_hit;
  assign stat.out_free   = !out_valid_r || out_ch.ready;

  a_found_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && scan_hit) |=> (SUM_W'(alloc_r) + SUM_W'(cnt_r) <= NP_S))
    else $error("first-fit run passes the end of the map");

  a_check_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && mode_r == WM_CHECK) |-> !mem_we)
    else $error("hint check wrote the map");

  a_clear_idle_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !proc)
    else $error("word processed during clearing pass");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r && !fail_r)
    else $error("result word not presented after finish");

endmodule

FILE: hw/rtl/bitmap_page_run_allocator_core.sv
// Release, lock and mark walk the map words that their page range spans, a word being 64 pages.
// Allocate: a hint check over the run's words if the run fits in the map, then if needed a
// first-fit scan of one map word per cycle, then on success the lock pass. One occupancy
// memory port pair serves every walk. The next word is taken while a result still waits.
// Reset: synchronous active-low; a clearing pass over every map word sets every page used
// before the first word is accepted.
module bitmap_page_run_allocator_core import bpra_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bpra_in_if.sink    in_ch,
  bpra_out_if.source out_ch
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bpra_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpra_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_operation  (in_ch.operation),
    .in_page_index (in_ch.page_index),
    .in_page_count (in_ch.page_count),
    .out_ch        (out_ch)
  );

endmodule

FILE: sim/bpra_checker.sv
// Scoreboard for the page-run allocator: mirrors the occupancy map and compares each result word.
`timescale 1ns / 1ps
module bpra_checker import bpra_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bpra_in_if   in_ch,
  bpra_out_if  out_ch,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [15:0]      start_page;
    logic             status;
    logic [CNT_W-1:0] used_pages;
  } page_result_t;

  bit               page_map [NUM_PAGES];
  logic [15:0]      hint;
  logic [CNT_W-1:0] held;
  page_result_t     awaiting [$];

  function automatic bit run_is_free(int unsigned first, int unsigned cnt);
    if (first > NUM_PAGES || cnt > NUM_PAGES - first) return 0;
    for (int unsigned i = 0; i < cnt; i++)
      if (page_map[first + i]) return 0;
    return 1;
  endfunction

  function automatic void touch_range(logic [OP_W-1:0] op, int unsigned first,
                                      int unsigned cnt);
    int unsigned p;
    for (int unsigned i = 0; i < cnt; i++) begin
      p = first + i;
      if (p < NUM_PAGES) begin
        case (op)
          OP_RELEASE: if (page_map[p]) begin
            page_map[p] = 0;
            if (held != 0) held = held - CNT_W'(1);
          end
          OP_LOCK: if (!page_map[p]) begin
            page_map[p] = 1;
            if (held != COUNT_MAX) held = held + CNT_W'(1);
          end
          default: page_map[p] = (op == OP_MARK_USED);
        endcase
      end
    end
  endfunction

  function automatic page_result_t apply_op(logic [OP_W-1:0] op, logic [15:0] idx,
                                            logic [CNT_W-1:0] cnt);
    page_result_t r;
    int unsigned  run;
    bit           found;
    r = '0;
    if (op == OP_ALLOC) begin
      if (run_is_free(hint, cnt)) begin
        r.start_page = hint;
        touch_range(OP_LOCK, hint, cnt);
      end else if (cnt == 0) begin
        r.start_page = 0;
      end else begin
        run = 0;
        found = 0;
        for (int unsigned p = 0; p < NUM_PAGES && !found; p++) begin
          if (page_map[p]) run = 0;
          else begin
            run++;
            if (run == cnt) begin
              found = 1;
              r.start_page = 16'(p + 1 - cnt);
            end
          end
        end
        if (found) touch_range(OP_LOCK, r.start_page, cnt);
        else r.status = 1;
      end
    end else if (op <= OP_MARK_USED) begin
      touch_range(op, idx, cnt);
      if (op == OP_RELEASE && cnt != 0) hint = 16'(idx + cnt - 1);
    end
    r.used_pages = held;
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    hint = '0;
    held = '0;
    foreach (page_map[i]) page_map[i] = 1;
  end

  always @(posedge clk) begin
    page_result_t want, got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.start_page, out_ch.status, out_ch.used_pages};
        if (awaiting.size() == 0) begin
          $display("%0t: unexpected result word start=%0d status=%0d used=%0d", $time,
                   got.start_page, got.status, got.used_pages);
          errors++;
        end else begin
          want = awaiting.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected start=%0d status=%0d used=%0d, ",
                     $time, want.start_page, want.status, want.used_pages,
                     "actual start=%0d status=%0d used=%0d",
                     got.start_page, got.status, got.used_pages);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaiting.push_back(apply_op(in_ch.operation, in_ch.page_index, in_ch.page_count));
    end
    pending = awaiting.size();
  end

endmodule

FILE: sim/tb.sv
// Top of the page-run allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import bpra_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   errors, pending;
  int   send_idle = 0;  // percent of cycles the sender holds back
  int   recv_stall = 0; // percent of cycles the receiver holds back

  bpra_in_if  in_ch ();
  bpra_out_if out_ch ();

  bitmap_page_run_allocator_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  bpra_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                    .errors(errors), .pending(pending));

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.operation = '0;
    in_ch.page_index = '0;
    in_ch.page_count = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk)
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);

  task automatic put_word(logic [OP_W-1:0] op, logic [15:0] idx, logic [CNT_W-1:0] cnt);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.operation <= op;
    in_ch.page_index <= idx;
    in_ch.page_count <= cnt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] cnt;
    int               roll;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // Directed part: full map at reset, then the edges of each operation.
    put_word(OP_ALLOC, 16'h0000, 17'd1);          // nothing free yet
    put_word(OP_ALLOC, 16'hffff, 17'd0);          // empty run at the hint
    put_word(OP_RELEASE, 16'h0000, 17'd0);        // hint stays
    put_word(OP_RELEASE, 16'h0010, 17'd300);      // count saturates at zero
    put_word(OP_ALLOC, 16'h0000, 17'd8);          // hint run runs past the freed area
    put_word(OP_ALLOC, 16'h0000, 17'd300);        // too long: fails
    put_word(OP_LOCK, 16'h0020, 17'd16);
    put_word(OP_MARK_FREE, 16'h0100, 17'd64);
    put_word(OP_MARK_USED, 16'h0110, 17'd4);
    put_word(OP_RELEASE, 16'hfff0, 17'd40);       // runs past the end, hint wraps
    put_word(OP_ALLOC, 16'h0000, 17'd5);          // hint run starts on a page the earlier allocation took
    put_word(OP_ALLOC, 16'h0000, 17'd20);         // hint run starts on a taken page
    put_word(3'd5, 16'hffff, 17'h1ffff);
    put_word(3'd6, 16'h5555, 17'd3);
    put_word(3'd7, 16'haaaa, 17'd3);
    put_word(OP_RELEASE, 16'h0000, 17'd65536);    // whole map free
    put_word(OP_ALLOC, 16'h0000, 17'd65536);      // whole map taken
    put_word(OP_MARK_FREE, 16'h0000, 17'd65536);
    put_word(OP_LOCK, 16'h0000, 17'd65536);       // count saturates at the top
    put_word(OP_RELEASE, 16'h8000, 17'd4096);
    put_word(OP_ALLOC, 16'h0000, 17'd0);
    drain();

    for (int n = 0; n < 1000; n++) begin
      case (n / 250)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 77; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 77; end
        default: begin send_idle = 17; recv_stall = 17; end
      endcase
      if (n == 600) drain();
      roll = $urandom_range(0, 99);
      if (roll < 40) op = OP_ALLOC;
      else if (roll < 70) op = OP_RELEASE;
      else if (roll < 82) op = OP_LOCK;
      else if (roll < 89) op = OP_MARK_FREE;
      else if (roll < 96) op = OP_MARK_USED;
      else op = OP_W'($urandom_range(5, 7));
      roll = $urandom_range(0, 99);
      if (roll < 2) cnt = CNT_W'($urandom_range(0, 65536));
      else if (roll < 20) cnt = CNT_W'($urandom_range(0, 2000));
      else cnt = CNT_W'($urandom_range(0, 100));
      put_word(op, 16'($urandom_range(0, 65535)), cnt);
    end
    drain();
    repeat (1500) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #400ms;
    $display("tb: errors");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bpra_pkg.sv
hw/rtl/bpra_in_if.sv
hw/rtl/bpra_ctl.sv
hw/rtl/bpra_dp.sv
hw/rtl/bitmap_page_run_allocator_core.sv
sim/bpra_checker.sv
sim/tb.sv
